@@ src/sliding_window_sorted_median_core_macros.svh @@
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_SORTED_MEDIAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_SORTED_MEDIAN_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SWSM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define SWSM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ src/swsm_pkg.sv @@
package swsm_pkg;

   // default sizes
   localparam int DEFAULT_DEPTH    = 64;
   localparam int DEFAULT_SAMPLE_W = 16;

   // configuration port
   localparam int CFG_LEN_W   = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_ASCENDING = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH    = 1'b1;

   localparam logic [CFG_LEN_W-1:0] LENGTH_RESET    = 7'd64;
   localparam logic                 ASCENDING_RESET = 1'b1;

   // input word operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // step strobes from the sequencer to the cell row
   typedef struct packed {
      logic capture;
      logic drop;
      logic insert;
      logic select;
      logic ascending;
   } ctrl_type;

   // per-cell move controls computed by the row
   typedef struct packed {
      logic take_up;
      logic take_dn;
      logic take_new;
   } shift_type;

endpackage

@@ src/swsm_cell.sv @@
module swsm_cell #(
   parameter int WINDOW_DEPTH = swsm_pkg::DEFAULT_DEPTH,
   parameter int SAMPLE_WIDTH = swsm_pkg::DEFAULT_SAMPLE_W,
   parameter int INDEX        = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swsm_pkg::ctrl_type                     ctrl,
   input  swsm_pkg::shift_type                    shift,
   input  logic signed [SAMPLE_WIDTH-1:0]         sample,
   input  logic [$clog2(2*WINDOW_DEPTH)-1:0]      new_tag,
   input  logic [$clog2(2*WINDOW_DEPTH)-1:0]      oldest_tag,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      count,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      last_idx,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      lo_idx,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      hi_idx,
   input  logic signed [SAMPLE_WIDTH-1:0]         up_val,
   input  logic [$clog2(2*WINDOW_DEPTH)-1:0]      up_tag,
   input  logic                                   up_beyond,
   input  logic signed [SAMPLE_WIDTH-1:0]         dn_val,
   input  logic [$clog2(2*WINDOW_DEPTH)-1:0]      dn_tag,
   output logic signed [SAMPLE_WIDTH-1:0]         val,
   output logic [$clog2(2*WINDOW_DEPTH)-1:0]      tag,
   output logic                                   beyond,
   output logic                                   beyond_free,
   output logic                                   match,
   output logic signed [SAMPLE_WIDTH-1:0]         removed_out,
   output logic signed [SAMPLE_WIDTH-1:0]         first_out,
   output logic signed [SAMPLE_WIDTH-1:0]         last_out,
   output logic signed [SAMPLE_WIDTH-1:0]         lo_out,
   output logic signed [SAMPLE_WIDTH-1:0]         hi_out
);

   localparam int CntW = $clog2(WINDOW_DEPTH + 1);
   localparam int TagW = $clog2(2 * WINDOW_DEPTH);
   localparam logic [CntW-1:0] Idx = CntW'(INDEX);

   logic signed [SAMPLE_WIDTH-1:0] val_ff, val_in;
   logic [TagW-1:0]                tag_ff, tag_in;
   logic                           beyond_ff, beyond_in;
   logic                           match_ff, match_in;
   logic                           sel_first_ff, sel_last_ff, sel_lo_ff, sel_hi_ff;
   logic                           sel_first_in, sel_last_in, sel_lo_in, sel_hi_in;
   logic                           occupied;

   assign occupied = (Idx < count);

   // next contents: capture flags, shift on drop or insert, latch the taps on select
   always_comb begin
      val_in       = val_ff;
      tag_in       = tag_ff;
      beyond_in    = beyond_ff;
      match_in     = match_ff;
      sel_first_in = sel_first_ff;
      sel_last_in  = sel_last_ff;
      sel_lo_in    = sel_lo_ff;
      sel_hi_in    = sel_hi_ff;
      if (ctrl.capture) begin
         match_in  = occupied && (tag_ff == oldest_tag);
         beyond_in = ctrl.ascending ? (val_ff > sample) : (val_ff < sample);
      end
      if (ctrl.drop && shift.take_up) begin
         val_in    = up_val;
         tag_in    = up_tag;
         beyond_in = up_beyond;
      end
      if (ctrl.insert) begin
         if (shift.take_dn) begin
            val_in = dn_val;
            tag_in = dn_tag;
         end else if (shift.take_new) begin
            val_in = sample;
            tag_in = new_tag;
         end
      end
      if (ctrl.select) begin
         sel_first_in = occupied && (Idx == '0);
         sel_last_in  = occupied && (Idx == last_idx);
         sel_lo_in    = occupied && (Idx == lo_idx);
         sel_hi_in    = occupied && (Idx == hi_idx);
      end
   end

   // payload
   always_ff @(posedge clock) begin
      val_ff <= val_in;
      tag_ff <= tag_in;
   end

   // flags
   always_ff @(posedge clock) begin
      if (reset) begin
         beyond_ff    <= 1'b0;
         match_ff     <= 1'b0;
         sel_first_ff <= 1'b0;
         sel_last_ff  <= 1'b0;
         sel_lo_ff    <= 1'b0;
         sel_hi_ff    <= 1'b0;
      end else begin
         beyond_ff    <= beyond_in;
         match_ff     <= match_in;
         sel_first_ff <= sel_first_in;
         sel_last_ff  <= sel_last_in;
         sel_lo_ff    <= sel_lo_in;
         sel_hi_ff    <= sel_hi_in;
      end
   end

   assign val         = val_ff;
   assign tag         = tag_ff;
   assign beyond      = beyond_ff;
   assign beyond_free = beyond_ff || !occupied;
   assign match       = match_ff;

   // masked taps onto the shared or buses
   assign removed_out = match_ff     ? val_ff : '0;
   assign first_out   = sel_first_ff ? val_ff : '0;
   assign last_out    = sel_last_ff  ? val_ff : '0;
   assign lo_out      = sel_lo_ff    ? val_ff : '0;
   assign hi_out      = sel_hi_ff    ? val_ff : '0;

endmodule

@@ src/swsm_row.sv @@
module swsm_row #(
   parameter int WINDOW_DEPTH = swsm_pkg::DEFAULT_DEPTH,
   parameter int SAMPLE_WIDTH = swsm_pkg::DEFAULT_SAMPLE_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swsm_pkg::ctrl_type                     ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]         sample,
   input  logic [$clog2(2*WINDOW_DEPTH)-1:0]      new_tag,
   input  logic [$clog2(2*WINDOW_DEPTH)-1:0]      oldest_tag,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      count,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      last_idx,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      lo_idx,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      hi_idx,
   output logic signed [SAMPLE_WIDTH-1:0]         removed_val,
   output logic signed [SAMPLE_WIDTH-1:0]         first_val,
   output logic signed [SAMPLE_WIDTH-1:0]         last_val,
   output logic signed [SAMPLE_WIDTH-1:0]         lo_val,
   output logic signed [SAMPLE_WIDTH-1:0]         hi_val
);

   localparam int TagW = $clog2(2 * WINDOW_DEPTH);

   logic signed [SAMPLE_WIDTH-1:0] val_vec     [WINDOW_DEPTH];
   logic [TagW-1:0]                tag_vec     [WINDOW_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] removed_vec [WINDOW_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] first_vec   [WINDOW_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] last_vec    [WINDOW_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] lo_vec      [WINDOW_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] hi_vec      [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]        beyond_vec;
   logic [WINDOW_DEPTH-1:0]        free_vec;
   logic [WINDOW_DEPTH-1:0]        match_vec;
   logic [WINDOW_DEPTH-1:0]        below_hit;
   logic [WINDOW_DEPTH-1:0]        above_all;

   for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_cell
      swsm_pkg::shift_type            shift;
      logic signed [SAMPLE_WIDTH-1:0] up_val, dn_val;
      logic [TagW-1:0]                up_tag, dn_tag;
      logic                           up_beyond;

      // eviction hit at or below this cell: pull from above
      assign below_hit[j] = |match_vec[j:0];
      // every occupied cell from here up lies beyond the new sample
      assign above_all[j] = &free_vec[WINDOW_DEPTH-1:j];

      if (j == WINDOW_DEPTH - 1) begin : g_top
         assign up_val        = val_vec[j];
         assign up_tag        = tag_vec[j];
         assign up_beyond     = beyond_vec[j];
         assign shift.take_up = 1'b0;
      end else begin : g_mid
         assign up_val        = val_vec[j+1];
         assign up_tag        = tag_vec[j+1];
         assign up_beyond     = beyond_vec[j+1];
         assign shift.take_up = below_hit[j];
      end

      if (j == 0) begin : g_bottom
         assign dn_val         = val_vec[j];
         assign dn_tag         = tag_vec[j];
         assign shift.take_dn  = 1'b0;
         assign shift.take_new = above_all[j];
      end else begin : g_upper
         assign dn_val         = val_vec[j-1];
         assign dn_tag         = tag_vec[j-1];
         assign shift.take_dn  = above_all[j-1];
         assign shift.take_new = above_all[j] && !above_all[j-1];
      end

      swsm_cell #(
         .WINDOW_DEPTH (WINDOW_DEPTH),
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .INDEX        (j)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .shift       (shift),
         .sample      (sample),
         .new_tag     (new_tag),
         .oldest_tag  (oldest_tag),
         .count       (count),
         .last_idx    (last_idx),
         .lo_idx      (lo_idx),
         .hi_idx      (hi_idx),
         .up_val      (up_val),
         .up_tag      (up_tag),
         .up_beyond   (up_beyond),
         .dn_val      (dn_val),
         .dn_tag      (dn_tag),
         .val         (val_vec[j]),
         .tag         (tag_vec[j]),
         .beyond      (beyond_vec[j]),
         .beyond_free (free_vec[j]),
         .match       (match_vec[j]),
         .removed_out (removed_vec[j]),
         .first_out   (first_vec[j]),
         .last_out    (last_vec[j]),
         .lo_out      (lo_vec[j]),
         .hi_out      (hi_vec[j])
      );
   end

   // or buses: at most one cell drives each
   always_comb begin
      removed_val = '0;
      first_val   = '0;
      last_val    = '0;
      lo_val      = '0;
      hi_val      = '0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         removed_val = removed_val | removed_vec[k];
         first_val   = first_val | first_vec[k];
         last_val    = last_val | last_vec[k];
         lo_val      = lo_val | lo_vec[k];
         hi_val      = hi_val | hi_vec[k];
      end
   end

endmodule

@@ src/sliding_window_sorted_median_core.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// req      | req_valid / req_stall      | req_func, req_sample
// rsp      | rsp_valid / rsp_stall      | first, last, median_twice, fill, full, removed
// csr      | csr_write_enable           | csr_index, csr_write_data
//
// one word at a time: the cell row moves one step per cycle (eviction shift, insertion
// shift, select), then the output register is loaded; an insert into a full window takes
// every step, a remove or a plain insert skips one shift, a remove from empty only selects.
// reset empties the window at once (fill count and oldest tag cleared), no clearing pass;
// order returns to ascending and length to 64.
// req_stall is high while a word is in flight; a stalled result holds the load step.
module sliding_window_sorted_median_core #(
   parameter int WINDOW_DEPTH = swsm_pkg::DEFAULT_DEPTH,
   parameter int SAMPLE_WIDTH = swsm_pkg::DEFAULT_SAMPLE_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_first_value,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_last_value,
   output logic signed [SAMPLE_WIDTH:0]           rsp_median_twice,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]      rsp_fill_count,
   output logic                                   rsp_window_full,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_removed_value,
   input  logic                                   csr_write_enable,
   input  logic [swsm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [swsm_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int CntW = $clog2(WINDOW_DEPTH + 1);
   localparam int TagW = $clog2(2 * WINDOW_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_INS,
      ST_SEL,
      ST_LOAD
   } state_type;

   state_type                          state_ff, state_in;
   logic [CntW-1:0]                    count_ff, count_in;
   logic [TagW-1:0]                    oldest_ff, oldest_in;
   logic                               asc_ff, asc_in;
   logic [swsm_pkg::CFG_LEN_W-1:0]     len_ff, len_in;
   logic                               op_ff, op_in;
   logic signed [SAMPLE_WIDTH-1:0]     sample_ff, sample_in;
   logic signed [SAMPLE_WIDTH-1:0]     removed_ff, removed_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]     first_ff, first_in;
   logic signed [SAMPLE_WIDTH-1:0]     last_ff, last_in;
   logic signed [SAMPLE_WIDTH:0]       median_ff, median_in;
   logic [CntW-1:0]                    fill_ff, fill_in;
   logic                               full_ff, full_in;
   logic signed [SAMPLE_WIDTH-1:0]     rsp_removed_ff, rsp_removed_in;

   logic                               accept;
   logic                               need_drop;
   logic [CntW-1:0]                    eff_len;
   logic [CntW-1:0]                    last_idx, lo_idx, hi_idx;
   logic [TagW-1:0]                    new_tag;
   logic signed [SAMPLE_WIDTH-1:0]     row_sample;
   swsm_pkg::ctrl_type                 ctrl;
   logic signed [SAMPLE_WIDTH-1:0]     row_removed, row_first, row_last, row_lo, row_hi;

   // window length: zero reads as one, saturated at the depth
   always_comb begin
      if (len_ff == '0) begin
         eff_len = CntW'(1);
      end else if (int'(len_ff) > WINDOW_DEPTH) begin
         eff_len = CntW'(WINDOW_DEPTH);
      end else begin
         eff_len = CntW'(len_ff);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign need_drop = (count_ff != '0) &&
                      ((req_func == swsm_pkg::FUNC_REMOVE) || (count_ff >= eff_len));

   // sorted positions of interest
   assign last_idx = count_ff - CntW'(1);
   assign lo_idx   = last_idx >> 1;
   assign hi_idx   = count_ff >> 1;
   assign new_tag  = oldest_ff + TagW'(count_ff);

   assign row_sample = (state_ff == ST_IDLE) ? req_sample : sample_ff;

   always_comb begin
      ctrl.capture   = accept;
      ctrl.drop      = (state_ff == ST_DROP);
      ctrl.insert    = (state_ff == ST_INS);
      ctrl.select    = (state_ff == ST_SEL);
      ctrl.ascending = asc_ff;
   end

   swsm_row #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_row (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .sample      (row_sample),
      .new_tag     (new_tag),
      .oldest_tag  (oldest_ff),
      .count       (count_ff),
      .last_idx    (last_idx),
      .lo_idx      (lo_idx),
      .hi_idx      (hi_idx),
      .removed_val (row_removed),
      .first_val   (row_first),
      .last_val    (row_last),
      .lo_val      (row_lo),
      .hi_val      (row_hi)
   );

   // sequencer and result register
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      oldest_in      = oldest_ff;
      asc_in         = asc_ff;
      len_in         = len_ff;
      op_in          = op_ff;
      sample_in      = sample_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      median_in      = median_ff;
      fill_in        = fill_ff;
      full_in        = full_ff;
      rsp_removed_in = rsp_removed_ff;

      // configuration writes
      if (csr_write_enable) begin
         unique case (csr_index)
            swsm_pkg::REG_ASCENDING: asc_in = csr_write_data[0];
            swsm_pkg::REG_LENGTH:    len_in = csr_write_data;
            default:                 len_in = len_ff;
         endcase
      end

      // result taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_func;
               sample_in  = req_sample;
               removed_in = '0;
               if (need_drop) begin
                  state_in = ST_DROP;
               end else if (req_func == swsm_pkg::FUNC_INSERT) begin
                  state_in = ST_INS;
               end else begin
                  state_in = ST_SEL;
               end
            end
         end
         ST_DROP: begin
            count_in  = count_ff - CntW'(1);
            oldest_in = oldest_ff + TagW'(1);
            if (op_ff == swsm_pkg::FUNC_REMOVE) begin
               removed_in = row_removed;
               state_in   = ST_SEL;
            end else begin
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            count_in = count_ff + CntW'(1);
            state_in = ST_SEL;
         end
         ST_SEL: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               first_in       = row_first;
               last_in        = row_last;
               median_in      = {row_lo[SAMPLE_WIDTH-1], row_lo} +
                                {row_hi[SAMPLE_WIDTH-1], row_hi};
               fill_in        = count_ff;
               full_in        = (count_ff >= eff_len);
               rsp_removed_in = removed_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         asc_ff       <= swsm_pkg::ASCENDING_RESET;
         len_ff       <= swsm_pkg::LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         asc_ff       <= asc_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      sample_ff      <= sample_in;
      removed_ff     <= removed_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      median_ff      <= median_in;
      fill_ff        <= fill_in;
      full_ff        <= full_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_value   = first_ff;
   assign rsp_last_value    = last_ff;
   assign rsp_median_twice  = median_ff;
   assign rsp_fill_count    = fill_ff;
   assign rsp_window_full   = full_ff;
   assign rsp_removed_value = rsp_removed_ff;

endmodule

@@ src/swsm_checker.sv @@
`include "sliding_window_sorted_median_core_macros.svh"

module swsm_checker #(
   parameter int WINDOW_DEPTH = swsm_pkg::DEFAULT_DEPTH,
   parameter int SAMPLE_WIDTH = swsm_pkg::DEFAULT_SAMPLE_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_func,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]         rsp_first_value,
   input  logic signed [SAMPLE_WIDTH-1:0]         rsp_last_value,
   input  logic signed [SAMPLE_WIDTH:0]           rsp_median_twice,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      rsp_fill_count,
   input  logic                                   rsp_window_full,
   input  logic signed [SAMPLE_WIDTH-1:0]         rsp_removed_value
);

   localparam int CntW = $clog2(WINDOW_DEPTH + 1);

   logic                          rsp_empty;
   logic                          rsp_zero;
   logic [SAMPLE_WIDTH:0]         req_word;
   logic [4*SAMPLE_WIDTH+CntW+1:0] rsp_word;

   // whole words as seen on the ports
   assign req_word  = {req_func, req_sample};
   assign rsp_word  = {rsp_first_value, rsp_last_value, rsp_median_twice,
                       rsp_fill_count, rsp_window_full, rsp_removed_value};
   assign rsp_empty = rsp_valid && (rsp_fill_count == '0);
   assign rsp_zero  = (rsp_first_value == '0) && (rsp_last_value == '0) &&
                      (rsp_median_twice == '0) && !rsp_window_full;

   // fill count never exceeds the cell row
   `SWSM_ASSERT_IMPLY(a_fill_bound, clock, reset, rsp_valid, rsp_fill_count <= CntW'(WINDOW_DEPTH))

   // one word in flight: input is held off right after a word is taken
   `SWSM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // an empty window reports zero values
   `SWSM_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_empty, rsp_zero)

   // a stalled result holds
   `SWSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // a stalled request word holds
   `SWSM_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_word))

endmodule

bind sliding_window_sorted_median_core swsm_checker #(
   .WINDOW_DEPTH (WINDOW_DEPTH),
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_func          (req_func),
   .req_sample        (req_sample),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_first_value   (rsp_first_value),
   .rsp_last_value    (rsp_last_value),
   .rsp_median_twice  (rsp_median_twice),
   .rsp_fill_count    (rsp_fill_count),
   .rsp_window_full   (rsp_window_full),
   .rsp_removed_value (rsp_removed_value)
);
